[src/ualu_pkg.sv]
// ----------------------------------------------------------------------------
// ualu_pkg - shared types and constants for the unsigned integer ALU
// Opcodes, compare codes, sequencer states and the control word that the
// sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package ualu_pkg;

    // Field widths that do not follow the data width
    localparam int CMD_W  = 4;
    localparam int AMT_W  = 8;
    localparam int CODE_W = 3;

    // Opcodes
    localparam logic [CMD_W-1:0] OP_ADD  = 4'd0;
    localparam logic [CMD_W-1:0] OP_SUB  = 4'd1;
    localparam logic [CMD_W-1:0] OP_MUL  = 4'd2;
    localparam logic [CMD_W-1:0] OP_DIV  = 4'd3;
    localparam logic [CMD_W-1:0] OP_CMP  = 4'd4;
    localparam logic [CMD_W-1:0] OP_SHL  = 4'd5;
    localparam logic [CMD_W-1:0] OP_SHR  = 4'd6;
    localparam logic [CMD_W-1:0] OP_ROTL = 4'd7;
    localparam logic [CMD_W-1:0] OP_ROTR = 4'd8;

    // Compare codes, a relative to b
    localparam logic [CODE_W-1:0] CMP_EQ = 3'd0;
    localparam logic [CODE_W-1:0] CMP_NE = 3'd1;
    localparam logic [CODE_W-1:0] CMP_GT = 3'd2;
    localparam logic [CODE_W-1:0] CMP_GE = 3'd3;
    localparam logic [CODE_W-1:0] CMP_LT = 3'd4;
    localparam logic [CODE_W-1:0] CMP_LE = 3'd5;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    // Control word from sequencer to datapath
    typedef struct packed {
        logic load;      // capture a new word
        logic step;      // run one iteration of the shared unit
        logic skip;      // rotate count reduced by a full turn, no move
        logic out_load;  // results ready for the output register
    } ctrl_t;

endpackage

[src/ualu_seq.sv]
// ----------------------------------------------------------------------------
// ualu_seq - iteration sequencer
// Loads the iteration count for each operation, steps the shared unit once
// per cycle and hands the finished word to the output register.
// ----------------------------------------------------------------------------
module ualu_seq #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [ualu_pkg::CMD_W-1:0] op,
    input  logic [ualu_pkg::AMT_W-1:0] amt,
    input  logic                   div_zero,
    input  logic                   out_free,
    output logic                   ready,
    output ualu_pkg::ctrl_t        ctrl
);
    import ualu_pkg::*;

    localparam logic [AMT_W-1:0] DW_CNT = AMT_W'(DATA_WIDTH);

    state_t           state_reg, state_next;
    logic [AMT_W-1:0] cnt_reg, cnt_next;
    logic [CMD_W-1:0] op_reg, op_next;
    logic [AMT_W-1:0] cnt_init;
    logic             is_rot;

    // Pick the number of iterations for the incoming word
    always_comb
    begin
        case (op)
            OP_ADD, OP_SUB, OP_CMP: cnt_init = AMT_W'(1);
            OP_MUL:                 cnt_init = DW_CNT;
            OP_DIV:                 cnt_init = div_zero ? '0 : DW_CNT;
            OP_SHL, OP_SHR:         cnt_init = (amt >= DW_CNT) ? '0 : amt;
            OP_ROTL, OP_ROTR:       cnt_init = amt;
            default:                cnt_init = '0;
        endcase
    end

    assign is_rot = (op_reg == OP_ROTL) || (op_reg == OP_ROTR);
    assign ready  = (state_reg == ST_IDLE);

    // Advance the sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        ctrl          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    cnt_next   = cnt_init;
                    op_next    = op;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    ctrl.step = 1'b1;
                    if (is_rot && (cnt_reg >= DW_CNT))
                    begin
                        ctrl.skip = 1'b1;
                        cnt_next  = cnt_reg - DW_CNT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - AMT_W'(1);
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            op_reg    <= OP_ADD;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
        end
    end

endmodule

[src/ualu_core.sv]
// ----------------------------------------------------------------------------
// ualu_core - operand registers and the shared add/subtract unit
// One adder serves add, sub, compare, the shift-and-add multiply and the
// restoring divide; a one-bit shifter serves shifts and rotates.
// ----------------------------------------------------------------------------
module ualu_core #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                        clk,
    input  ualu_pkg::ctrl_t             ctrl,
    input  logic [ualu_pkg::CMD_W-1:0]  op,
    input  logic [DATA_WIDTH-1:0]       in_a,
    input  logic [DATA_WIDTH-1:0]       in_b,
    input  logic                        amt_big,
    input  logic [ualu_pkg::CODE_W-1:0] code,
    output logic [DATA_WIDTH-1:0]       res,
    output logic [DATA_WIDTH-1:0]       rem,
    output logic                        cmp_true,
    output logic                        div_zero
);
    import ualu_pkg::*;

    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [CMD_W-1:0]      op_reg, op_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic                  cmp_reg, cmp_next;
    logic                  dz_reg, dz_next;

    logic [DATA_WIDTH-1:0] add_x, add_y;
    logic                  add_inv;
    logic [DATA_WIDTH:0]   add_sum;
    logic                  carry;
    logic                  eq;
    logic                  take;

    // Select the adder operands for the current operation
    always_comb
    begin
        add_x   = a_reg;
        add_y   = b_reg;
        add_inv = 1'b0;
        case (op_reg)
            OP_SUB, OP_CMP:
            begin
                add_inv = 1'b1;
            end
            OP_MUL:
            begin
                add_x = acc_reg;
            end
            OP_DIV:
            begin
                add_x   = {acc_reg[DATA_WIDTH-2:0], a_reg[DATA_WIDTH-1]};
                add_inv = 1'b1;
            end
            default:
            begin
                add_inv = 1'b0;
            end
        endcase
    end

    // Shared adder; carry out is the no-borrow flag when subtracting
    assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {DATA_WIDTH{add_inv}}}
                   + (DATA_WIDTH + 1)'(add_inv);
    assign carry   = add_sum[DATA_WIDTH];
    assign eq      = (a_reg == b_reg);
    // Shifted-out top bit means the partial remainder exceeds any divisor
    assign take    = acc_reg[DATA_WIDTH-1] | carry;

    // Next values of the working registers
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        op_next   = op_reg;
        code_next = code_reg;
        cmp_next  = cmp_reg;
        dz_next   = dz_reg;
        if (ctrl.load)
        begin
            op_next   = op;
            code_next = code;
            b_next    = in_b;
            acc_next  = '0;
            cmp_next  = 1'b0;
            dz_next   = (in_b == '0);
            a_next    = ((op == OP_SHL || op == OP_SHR) && amt_big) ? '0 : in_a;
        end
        else if (ctrl.step && !ctrl.skip)
        begin
            case (op_reg)
                OP_ADD, OP_SUB:
                begin
                    acc_next = add_sum[DATA_WIDTH-1:0];
                end
                OP_CMP:
                begin
                    case (code_reg)
                        CMP_EQ:  cmp_next = eq;
                        CMP_NE:  cmp_next = !eq;
                        CMP_GT:  cmp_next = carry && !eq;
                        CMP_GE:  cmp_next = carry;
                        CMP_LT:  cmp_next = !carry;
                        CMP_LE:  cmp_next = !carry || eq;
                        default: cmp_next = 1'b0;
                    endcase
                end
                OP_MUL:
                begin
                    if (a_reg[0])
                    begin
                        acc_next = add_sum[DATA_WIDTH-1:0];
                    end
                    a_next = a_reg >> 1;
                    b_next = b_reg << 1;
                end
                OP_DIV:
                begin
                    acc_next = take ? add_sum[DATA_WIDTH-1:0]
                                    : {acc_reg[DATA_WIDTH-2:0], a_reg[DATA_WIDTH-1]};
                    a_next   = {a_reg[DATA_WIDTH-2:0], take};
                end
                OP_SHL:  a_next = a_reg << 1;
                OP_SHR:  a_next = a_reg >> 1;
                OP_ROTL: a_next = {a_reg[DATA_WIDTH-2:0], a_reg[DATA_WIDTH-1]};
                OP_ROTR: a_next = {a_reg[0], a_reg[DATA_WIDTH-1:1]};
                default: a_next = a_reg;
            endcase
        end
    end

    // Hold the working registers
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        op_reg   <= op_next;
        code_reg <= code_next;
        cmp_reg  <= cmp_next;
        dz_reg   <= dz_next;
    end

    // Route the finished word to the result fields
    always_comb
    begin
        res      = '0;
        rem      = '0;
        cmp_true = 1'b0;
        div_zero = 1'b0;
        case (op_reg)
            OP_ADD, OP_SUB, OP_MUL:
            begin
                res = acc_reg;
            end
            OP_DIV:
            begin
                div_zero = dz_reg;
                if (!dz_reg)
                begin
                    res = a_reg;
                    rem = acc_reg;
                end
            end
            OP_CMP:
            begin
                cmp_true = cmp_reg;
            end
            OP_SHL, OP_SHR, OP_ROTL, OP_ROTR:
            begin
                res = a_reg;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

[src/uint64_integer_alu.sv]
// ----------------------------------------------------------------------------
// uint64_integer_alu - iterative unsigned integer ALU
//
//  channel | direction | carries
//  s_*     | in        | tuser: cmd; tdata: operand_a, operand_b, shift_amount,
//          |           |        compare_code
//  m_*     | out       | tdata: result, remainder, compare_true;
//          |           | tuser: divide_by_zero
//
// Each word runs n iterations of the shared adder/shifter, with n being 1
// for add, sub and compare, DATA_WIDTH for mul and divmod (none for a zero
// divisor), the amount for shl/shr below DATA_WIDTH and none from DATA_WIDTH
// up, amount mod DATA_WIDTH moves plus amount / DATA_WIDTH full-turn skips
// for rotates, and none for an unknown opcode.
// s_tready is low from acceptance until the result moves to the output
// register; the sequencer waits in its last state while the output register
// holds a word not yet taken, and frees s_tready as soon as the move is made.
// Reset is asynchronous, active low, and clears the sequencer and m_tvalid.
// ----------------------------------------------------------------------------
module uint64_integer_alu #(
    parameter int DATA_WIDTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // operand_a, operand_b, shift_amount, compare_code, zero fill
    input  logic [((2*DATA_WIDTH + ualu_pkg::AMT_W + ualu_pkg::CODE_W + 7)/8)*8-1:0]
                 s_tdata,
    // cmd
    input  logic [ualu_pkg::CMD_W-1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // result, remainder, compare_true, zero fill
    output logic [((2*DATA_WIDTH + 1 + 7)/8)*8-1:0] m_tdata,
    // divide_by_zero
    output logic [0:0] m_tuser
);
    import ualu_pkg::*;

    localparam int OUT_W  = ((2*DATA_WIDTH + 1 + 7)/8)*8;
    localparam int AMT_LO = 2*DATA_WIDTH;
    localparam int CODE_LO = AMT_LO + AMT_W;
    localparam logic [AMT_W-1:0] DW_CNT = AMT_W'(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] in_a, in_b;
    logic [AMT_W-1:0]      in_amt;
    logic [CODE_W-1:0]     in_code;
    logic                  amt_big;
    logic                  seq_ready;
    logic                  out_free;
    ctrl_t                 ctrl;

    logic [DATA_WIDTH-1:0] res, rem;
    logic                  cmp_true, div_zero;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]      m_data_reg, m_data_next;
    logic                  m_user_reg, m_user_next;

    // Unpack the input word
    assign in_a    = s_tdata[DATA_WIDTH-1:0];
    assign in_b    = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign in_amt  = s_tdata[AMT_LO +: AMT_W];
    assign in_code = s_tdata[CODE_LO +: CODE_W];
    assign amt_big = (in_amt >= DW_CNT);

    assign s_tready = seq_ready;
    assign out_free = !m_valid_reg || m_tready;

    ualu_seq #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .op       (s_tuser),
        .amt      (in_amt),
        .div_zero (in_b == '0),
        .out_free (out_free),
        .ready    (seq_ready),
        .ctrl     (ctrl)
    );

    ualu_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .clk      (clk),
        .ctrl     (ctrl),
        .op       (s_tuser),
        .in_a     (in_a),
        .in_b     (in_b),
        .amt_big  (amt_big),
        .code     (in_code),
        .res      (res),
        .rem      (rem),
        .cmp_true (cmp_true),
        .div_zero (div_zero)
    );

    // Load the output register, drop the word once taken
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (ctrl.out_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_W'({cmp_true, rem, res});
            m_user_next  = div_zero;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again while a word is in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten before it was taken");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_user_reg) |-> (m_data_reg[2*DATA_WIDTH-1:0] == '0))
        else $error("divide by zero with non-zero quotient or remainder");

    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[2*DATA_WIDTH])
            |-> (m_data_reg[2*DATA_WIDTH-1:0] == '0) && !m_user_reg)
        else $error("compare result carries other fields");

endmodule
